// File: src/cmps_pkg.sv
// Shared constants and types for the minimum capacity partition search.
`default_nettype none
package cmps_pkg;

  localparam int MAX_STAGES  = 1024;
  localparam int LENGTH_BITS = 16;
  localparam int ADDR_W      = $clog2(MAX_STAGES);
  localparam int CNT_W       = $clog2(MAX_STAGES + 1);
  localparam int CAP_W       = 26;
  localparam int REFUEL_W    = 10;
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;

  localparam logic REG_REFUELS_ALLOWED = 1'b0;

  typedef struct packed {
    logic [CNT_W-1:0]       count;
    logic [CAP_W-1:0]       sum;
    logic [LENGTH_BITS-1:0] max;
  } search_cmd_t;

  typedef struct packed {
    logic             done;
    logic [CAP_W-1:0] result;
  } search_rsp_t;

endpackage
`default_nettype wire

// File: src/cmps_stage_store.sv
// Stage length memory: one write port, one registered read port.
`default_nettype none
module cmps_stage_store (
  input  wire logic                            clk_i,
  input  wire logic                            wr_en_i,
  input  wire logic [cmps_pkg::ADDR_W-1:0]      wr_addr_i,
  input  wire logic [cmps_pkg::LENGTH_BITS-1:0] wr_data_i,
  input  wire logic                            rd_en_i,
  input  wire logic [cmps_pkg::ADDR_W-1:0]      rd_addr_i,
  output logic      [cmps_pkg::LENGTH_BITS-1:0] rd_data_o
);
  import cmps_pkg::*;

  logic [LENGTH_BITS-1:0] mem [MAX_STAGES];
  logic [LENGTH_BITS-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule
`default_nettype wire

// File: src/cmps_search.sv
// Binary search over capacity with a greedy route walk through the stage memory.
`default_nettype none
module cmps_search (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start_i,
  input  wire cmps_pkg::search_cmd_t           cmd_i,
  input  wire logic [cmps_pkg::REFUEL_W-1:0]    refuels_i,
  output logic                                 rd_en_o,
  output logic      [cmps_pkg::ADDR_W-1:0]      rd_addr_o,
  input  wire logic [cmps_pkg::LENGTH_BITS-1:0] rd_data_i,
  output cmps_pkg::search_rsp_t                rsp_o,
  input  wire logic                            take_i,
  output logic                                 idle_o
);
  import cmps_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_MID   = 3'd2;
  localparam logic [2:0] S_WALK  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]          state_q, state_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [CAP_W-1:0]    low_q, low_d;
  logic [CAP_W-1:0]    high_q, high_d;
  logic [CAP_W-1:0]    span_q, span_d;
  logic [CAP_W-1:0]    mid_q, mid_d;
  logic [CAP_W-1:0]    fuel_q, fuel_d;
  logic [REFUEL_W-1:0] refl_q, refl_d;
  logic [CNT_W-1:0]    issue_q, issue_d;
  logic [CNT_W-1:0]    proc_q, proc_d;
  logic                data_vld_q;
  logic [CAP_W-1:0]    need;
  logic [CAP_W-1:0]    mid_calc;
  logic                rd_en;
  logic                step_fail;
  logic [CAP_W-1:0]    step_fuel;
  logic [REFUEL_W-1:0] step_refl;
  logic                step_last;

  assign need     = CAP_W'(rd_data_i);
  assign mid_calc = low_q + (span_q >> 1);
  assign rd_en    = (state_q == S_WALK) && (issue_q != count_q);
  assign step_last = (proc_q == (count_q - 1'b1));

  always_comb begin
    step_fail = 1'b0;
    step_fuel = fuel_q;
    step_refl = refl_q;
    if (fuel_q >= need) begin
      step_fuel = fuel_q - need;
    end else if (refl_q != '0) begin
      step_refl = refl_q - 1'b1;
      if (mid_q < need) begin
        step_fail = 1'b1;
      end else begin
        step_fuel = mid_q - need;
      end
    end else begin
      step_fail = 1'b1;
    end
  end

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    low_d   = low_q;
    high_d  = high_q;
    span_d  = span_q;
    mid_d   = mid_q;
    fuel_d  = fuel_q;
    refl_d  = refl_q;
    issue_d = issue_q;
    proc_d  = proc_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          count_d = cmd_i.count;
          low_d   = CAP_W'(cmd_i.max);
          high_d  = cmd_i.sum;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        span_d = high_q - low_q;
        if (low_q < high_q) begin
          state_d = S_MID;
        end else begin
          state_d = S_DONE;
        end
      end
      S_MID: begin
        mid_d   = mid_calc;
        fuel_d  = mid_calc;
        refl_d  = refuels_i;
        issue_d = '0;
        proc_d  = '0;
        state_d = S_WALK;
      end
      S_WALK: begin
        if (rd_en) begin
          issue_d = issue_q + 1'b1;
        end
        if (data_vld_q) begin
          fuel_d = step_fuel;
          refl_d = step_refl;
          proc_d = proc_q + 1'b1;
          if (step_fail) begin
            low_d   = mid_q + 1'b1;
            state_d = S_CHECK;
          end else if (step_last) begin
            high_d  = mid_q;
            state_d = S_CHECK;
          end
        end
      end
      S_DONE: begin
        if (take_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      data_vld_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      data_vld_q <= rd_en;
    end
  end

  always_ff @(posedge clk_i) begin
    count_q <= count_d;
    low_q   <= low_d;
    high_q  <= high_d;
    span_q  <= span_d;
    mid_q   <= mid_d;
    fuel_q  <= fuel_d;
    refl_q  <= refl_d;
    issue_q <= issue_d;
    proc_q  <= proc_d;
  end

  assign rd_en_o     = rd_en;
  assign rd_addr_o   = issue_q[ADDR_W-1:0];
  assign rsp_o.done   = (state_q == S_DONE);
  assign rsp_o.result = low_q;
  assign idle_o      = (state_q == S_IDLE);

endmodule
`default_nettype wire

// File: src/min_capacity_partition_search_top.sv
// Top level: stage loading, configuration register, search and result register.
// After the flagged last stage the search runs binary search steps over capacity; each
// step walks the N stored stages in order until one fails or the last one is done.
// Throughput: one stage item per cycle while loading, when in_stall_o is low; the
// search walks the stage memory one stage per cycle, and a new list waits until idle.
// Reset: asynchronous, active low; clears control state and the refill limit to 0.
`default_nettype none
module min_capacity_partition_search_top (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [cmps_pkg::LENGTH_BITS-1:0] stage_length_i,
  input  wire logic                            last_stage_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic      [cmps_pkg::CAP_W-1:0]       min_capacity_o,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [cmps_pkg::PADDR_W-1:0]     paddr,
  input  wire logic [cmps_pkg::PDATA_W-1:0]     pwdata,
  output logic      [cmps_pkg::PDATA_W-1:0]     prdata,
  output logic                                 pready
);
  import cmps_pkg::*;

  logic [REFUEL_W-1:0]    refuels_q;
  logic [CNT_W-1:0]       cnt_q;
  logic [CAP_W-1:0]       sum_q;
  logic [LENGTH_BITS-1:0] max_q;
  logic                   start_q;
  logic                   out_valid_q;
  logic [CAP_W-1:0]       out_data_q;
  logic                   in_accept;
  logic                   room;
  logic                   cfg_wr;
  logic                   search_idle;
  logic                   take;
  logic                   rd_en;
  logic [ADDR_W-1:0]      rd_addr;
  logic [LENGTH_BITS-1:0] rd_data;
  search_cmd_t            cmd;
  search_rsp_t            rsp;

  assign in_stall_o = start_q | ~search_idle;
  assign in_accept  = in_valid_i & ~in_stall_o;
  assign room       = (cnt_q < CNT_W'(MAX_STAGES));
  assign cfg_wr     = psel & penable & pwrite & pready;
  assign pready     = 1'b1;
  assign prdata     = (paddr[PADDR_W-1] == REG_REFUELS_ALLOWED) ? PDATA_W'(refuels_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      refuels_q <= '0;
    end else if (cfg_wr && (paddr[PADDR_W-1] == REG_REFUELS_ALLOWED)) begin
      refuels_q <= pwdata[REFUEL_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      sum_q   <= '0;
      max_q   <= '0;
      start_q <= 1'b0;
    end else if (start_q) begin
      cnt_q   <= '0;
      sum_q   <= '0;
      max_q   <= '0;
      start_q <= 1'b0;
    end else if (in_accept) begin
      if (room) begin
        cnt_q <= cnt_q + 1'b1;
        sum_q <= sum_q + CAP_W'(stage_length_i);
        if (stage_length_i > max_q) begin
          max_q <= stage_length_i;
        end
      end
      start_q <= last_stage_i;
    end
  end

  assign cmd.count = cnt_q;
  assign cmd.sum   = sum_q;
  assign cmd.max   = max_q;

  cmps_stage_store u_store (
    .clk_i     (clk_i),
    .wr_en_i   (in_accept & room),
    .wr_addr_i (cnt_q[ADDR_W-1:0]),
    .wr_data_i (stage_length_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  cmps_search u_search (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_q),
    .cmd_i     (cmd),
    .refuels_i (refuels_q),
    .rd_en_o   (rd_en),
    .rd_addr_o (rd_addr),
    .rd_data_i (rd_data),
    .rsp_o     (rsp),
    .take_i    (take),
    .idle_o    (search_idle)
  );

  assign take = rsp.done & (~out_valid_q | ~out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_data_q <= rsp.result;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign min_capacity_o = out_data_q;

endmodule
`default_nettype wire
